// ===== hdl/gvae_pkg.sv =====
// Shared types, constants and arithmetic helpers of the gravity-vector attitude estimator.
package gvae_pkg;

  localparam int GV_FRAC      = 20;
  localparam int GV_W         = GV_FRAC + 4;
  localparam int ACC_SHIFT    = GV_FRAC - 12;
  localparam int CORDIC_STEPS = 16;
  localparam int ITER_W       = $clog2(CORDIC_STEPS);
  localparam int TAB_LEN      = 24;

  localparam int D_W  = 30;               // gyro delta, Q.22
  localparam int MA_W = 31;               // multiplier operand a
  localparam int MB_W = GV_W + 1;         // multiplier operand b
  localparam int P_W  = MA_W + MB_W;      // product
  localparam int SUM_W = P_W + 2;         // product accumulator
  localparam int CW   = GV_W + 4;         // CORDIC x / y
  localparam int AW   = 34;               // CORDIC angle, Q.30

  localparam logic signed [AW-1:0] ANG_HALF_PI = AW'(64'sd1686629713);

  localparam logic signed [63:0] GV_MAX  = (64'sd1 <<< (GV_W - 1)) - 64'sd1;
  localparam logic signed [63:0] GV_MIN  = -GV_MAX - 64'sd1;
  localparam logic signed [63:0] YAW_MAX = 64'sd2147483647;
  localparam logic signed [63:0] YAW_MIN = -YAW_MAX - 64'sd1;

  localparam logic [16:0] GAIN_ONE = 17'h10000;

  typedef enum logic [3:0] {
    M_NONE, M_D0, M_D1, M_D2, M_RZ0, M_RZ1, M_RX0, M_RX1, M_RY0, M_RY1,
    M_BV0, M_BA0, M_BV1, M_BA1, M_BV2, M_BA2
  } mul_sel_e;

  typedef enum logic [2:0] {
    A_NONE, A_D0, A_D1, A_D2, A_LOAD, A_ADD, A_SUB
  } acc_sel_e;

  typedef enum logic [2:0] {
    W_NONE, W_Z, W_X, W_Y, W_COMMIT, W_B0, W_B1, W_B2
  } wr_sel_e;

  typedef enum logic [2:0] {
    C_NONE, C_LD_PITCH, C_ITER, C_LD_KX, C_LD_ROLL
  } cord_sel_e;

  typedef enum logic [1:0] {
    N_NONE, N_PITCH, N_KX
  } done_sel_e;

  typedef struct packed {
    logic              load;
    mul_sel_e          mul;
    acc_sel_e          acc;
    wr_sel_e           wr;
    cord_sel_e         cord;
    done_sel_e         done;
    logic [ITER_W-1:0] iter;
    logic              out_load;
  } gvae_cmd_t;

  typedef struct packed {
    logic init_item;
  } gvae_stat_t;

  // Round half away from zero, then shift right by s.
  function automatic logic signed [63:0] rnd_shr(logic signed [63:0] v, int s);
    logic signed [63:0] h;
    logic signed [63:0] neg;
    h   = 64'sd1 <<< (s - 1);
    neg = signed'({63'b0, v[63]});
    return (v + h - neg) >>> s;
  endfunction

  function automatic logic signed [GV_W-1:0] sat_gv(logic signed [63:0] v);
    logic signed [63:0] c;
    c = (v > GV_MAX) ? GV_MAX : ((v < GV_MIN) ? GV_MIN : v);
    return GV_W'(c);
  endfunction

  function automatic logic signed [31:0] sat_yaw(logic signed [63:0] v);
    logic signed [63:0] c;
    c = (v > YAW_MAX) ? YAW_MAX : ((v < YAW_MIN) ? YAW_MIN : v);
    return 32'(c);
  endfunction

  // Arctangent of 2^-i in Q.30, truncated.
  function automatic logic [30:0] atan_q30(int i);
    logic [30:0] r;
    case (i)
      0:  r = 31'd843314856;
      1:  r = 31'd497837829;
      2:  r = 31'd263043836;
      3:  r = 31'd133525158;
      4:  r = 31'd67021686;
      5:  r = 31'd33543515;
      6:  r = 31'd16775850;
      7:  r = 31'd8388437;
      8:  r = 31'd4194282;
      9:  r = 31'd2097149;
      10: r = 31'd1048575;
      11: r = 31'd524287;
      12: r = 31'd262143;
      13: r = 31'd131071;
      14: r = 31'd65535;
      15: r = 31'd32767;
      16: r = 31'd16383;
      17: r = 31'd8191;
      18: r = 31'd4095;
      19: r = 31'd2047;
      20: r = 31'd1023;
      21: r = 31'd511;
      22: r = 31'd255;
      23: r = 31'd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/gvae_ctrl.sv =====
// Sequencer that steps the datapath through rotation, blend and three CORDIC passes; init samples skip rotation.
module gvae_ctrl import gvae_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  gvae_stat_t stat_i,
  output gvae_cmd_t  cmd_o
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_D0     = 5'd1;
  localparam logic [4:0] ST_D1     = 5'd2;
  localparam logic [4:0] ST_D2     = 5'd3;
  localparam logic [4:0] ST_RZ0    = 5'd4;
  localparam logic [4:0] ST_RZ1    = 5'd5;
  localparam logic [4:0] ST_RX0    = 5'd6;
  localparam logic [4:0] ST_RX1    = 5'd7;
  localparam logic [4:0] ST_RY0    = 5'd8;
  localparam logic [4:0] ST_RY1    = 5'd9;
  localparam logic [4:0] ST_RC     = 5'd10;
  localparam logic [4:0] ST_RW     = 5'd11;
  localparam logic [4:0] ST_COMMIT = 5'd12;
  localparam logic [4:0] ST_B0V    = 5'd13;
  localparam logic [4:0] ST_B0A    = 5'd14;
  localparam logic [4:0] ST_B1V    = 5'd15;
  localparam logic [4:0] ST_B1A    = 5'd16;
  localparam logic [4:0] ST_B2V    = 5'd17;
  localparam logic [4:0] ST_B2A    = 5'd18;
  localparam logic [4:0] ST_BE1    = 5'd19;
  localparam logic [4:0] ST_BE2    = 5'd20;
  localparam logic [4:0] ST_PL     = 5'd21;
  localparam logic [4:0] ST_PI     = 5'd22;
  localparam logic [4:0] ST_PD     = 5'd23;
  localparam logic [4:0] ST_KI     = 5'd24;
  localparam logic [4:0] ST_KD     = 5'd25;
  localparam logic [4:0] ST_RL     = 5'd26;
  localparam logic [4:0] ST_RI     = 5'd27;
  localparam logic [4:0] ST_FIN    = 5'd28;

  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

  logic [4:0]        state_q, state_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              out_valid_q, out_valid_d;
  logic              iter_last;
  logic              out_fire;

  assign iter_last   = (iter_q == ITER_LAST);
  assign out_fire    = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    iter_d      = iter_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_fire) begin
      out_valid_d = 1'b1;
    end
    unique case (state_q) inside
      ST_IDLE:   if (in_valid_i) state_d = ST_D0;
      ST_D0:     state_d = stat_i.init_item ? ST_B0V : ST_D1;
      ST_D1:     state_d = ST_D2;
      ST_D2:     state_d = ST_RZ0;
      ST_RZ0:    state_d = ST_RZ1;
      ST_RZ1:    state_d = ST_RX0;
      ST_RX0:    state_d = ST_RX1;
      ST_RX1:    state_d = ST_RY0;
      ST_RY0:    state_d = ST_RY1;
      ST_RY1:    state_d = ST_RC;
      ST_RC:     state_d = ST_RW;
      ST_RW:     state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_B0V;
      ST_B0V:    state_d = ST_B0A;
      ST_B0A:    state_d = ST_B1V;
      ST_B1V:    state_d = ST_B1A;
      ST_B1A:    state_d = ST_B2V;
      ST_B2V:    state_d = ST_B2A;
      ST_B2A:    state_d = ST_BE1;
      ST_BE1:    state_d = ST_BE2;
      ST_BE2:    state_d = ST_PL;
      ST_PL:     state_d = ST_PI;
      ST_PI, ST_KI, ST_RI: begin
        iter_d = iter_q + 1'b1;
        if (iter_last) begin
          iter_d = '0;
          state_d = (state_q == ST_PI) ? ST_PD : ((state_q == ST_KI) ? ST_KD : ST_FIN);
        end
      end
      ST_PD:     state_d = ST_KI;
      ST_KD:     state_d = ST_RL;
      ST_RL:     state_d = ST_RI;
      ST_FIN:    if (out_fire) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = in_valid_i && (state_q == ST_IDLE);
    cmd_o.iter     = iter_q;
    cmd_o.out_load = out_fire;
    unique case (state_q) inside
      ST_D0:     cmd_o.mul = M_D0;
      ST_D1:     begin cmd_o.mul = M_D1;  cmd_o.acc = A_D0; end
      ST_D2:     begin cmd_o.mul = M_D2;  cmd_o.acc = A_D1; end
      ST_RZ0:    begin cmd_o.mul = M_RZ0; cmd_o.acc = A_D2; end
      ST_RZ1:    begin cmd_o.mul = M_RZ1; cmd_o.acc = A_LOAD; end
      ST_RX0:    begin cmd_o.mul = M_RX0; cmd_o.acc = A_ADD; end
      ST_RX1:    begin cmd_o.mul = M_RX1; cmd_o.acc = A_LOAD; cmd_o.wr = W_Z; end
      ST_RY0:    begin cmd_o.mul = M_RY0; cmd_o.acc = A_SUB; end
      ST_RY1:    begin cmd_o.mul = M_RY1; cmd_o.acc = A_LOAD; cmd_o.wr = W_X; end
      ST_RC:     cmd_o.acc = A_ADD;
      ST_RW:     cmd_o.wr = W_Y;
      ST_COMMIT: cmd_o.wr = W_COMMIT;
      ST_B0V:    cmd_o.mul = M_BV0;
      ST_B0A:    begin cmd_o.mul = M_BA0; cmd_o.acc = A_LOAD; end
      ST_B1V:    begin cmd_o.mul = M_BV1; cmd_o.acc = A_ADD; end
      ST_B1A:    begin cmd_o.mul = M_BA1; cmd_o.acc = A_LOAD; cmd_o.wr = W_B0; end
      ST_B2V:    begin cmd_o.mul = M_BV2; cmd_o.acc = A_ADD; end
      ST_B2A:    begin cmd_o.mul = M_BA2; cmd_o.acc = A_LOAD; cmd_o.wr = W_B1; end
      ST_BE1:    cmd_o.acc = A_ADD;
      ST_BE2:    cmd_o.wr = W_B2;
      ST_PL:     cmd_o.cord = C_LD_PITCH;
      ST_PI, ST_KI, ST_RI: cmd_o.cord = C_ITER;
      ST_PD:     begin cmd_o.done = N_PITCH; cmd_o.cord = C_LD_KX; end
      ST_KD:     cmd_o.done = N_KX;
      ST_RL:     cmd_o.cord = C_LD_ROLL;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/gvae_dp.sv =====
// Datapath: item registers, shared multiplier with accumulator, gravity state and CORDIC.
module gvae_dp import gvae_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  gvae_cmd_t          cmd_i,
  output gvae_stat_t         stat_o,
  input  logic               cmd_bit_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] gyro_roll_rate_i,
  input  logic signed [15:0] gyro_pitch_rate_i,
  input  logic signed [15:0] gyro_yaw_rate_i,
  input  logic [19:0]        dt_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [15:0] pitch_angle_o,
  output logic signed [31:0] yaw_angle_o
);

  localparam logic CFG_UPDATE_GAIN = 1'b0;
  localparam logic CFG_INIT_GAIN   = 1'b1;

  logic [15:0]              update_gain_q, init_gain_q;
  logic                     init_q;
  logic signed [15:0]       accel_q [3];
  logic signed [15:0]       rate_q  [3];
  logic [19:0]              dt_q;
  logic signed [GV_W-1:0]   gv_q [3];
  logic signed [GV_W-1:0]   nv_q [3];
  logic signed [31:0]       yaw_q;
  logic signed [D_W-1:0]    d_q [3];
  logic signed [P_W-1:0]    prod_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [CW-1:0]     cx_q, cy_q, r_q, kx_q;
  logic signed [AW-1:0]     ang_q;
  logic                     zero_q;
  logic signed [15:0]       pitch_q;
  logic signed [15:0]       roll_out_q, pitch_out_q;
  logic signed [31:0]       yaw_out_q;

  logic [15:0]              gain;
  logic [16:0]              gain_inv;
  logic signed [GV_W-1:0]   accw [3];
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [MB_W-1:0]   dt_op;
  logic signed [MA_W-1:0]   gain_op, inv_op;
  logic signed [63:0]       sum_rnd22, sum_rnd16;
  logic signed [CW-1:0]     ld_x, ld_y, px, py;
  logic signed [AW-1:0]     pang;
  logic signed [CW-1:0]     xs, ys;
  logic signed [AW-1:0]     tab;
  logic signed [AW-1:0]     ang_fin;
  logic signed [CW-1:0]     gx, gx_abs;

  assign stat_o.init_item = init_q;

  assign gain     = init_q ? init_gain_q : update_gain_q;
  assign gain_inv = 17'(GAIN_ONE - {1'b0, gain});
  assign gain_op  = MA_W'(signed'({1'b0, gain}));
  assign inv_op   = MA_W'(signed'({1'b0, gain_inv}));
  assign dt_op    = MB_W'(signed'({1'b0, dt_q}));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      accw[i] = GV_W'(accel_q[i]) <<< ACC_SHIFT;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul)
      M_D0:    begin mul_a = MA_W'(rate_q[0]); mul_b = dt_op; end
      M_D1:    begin mul_a = MA_W'(rate_q[1]); mul_b = dt_op; end
      M_D2:    begin mul_a = MA_W'(rate_q[2]); mul_b = dt_op; end
      M_RZ0:   begin mul_a = MA_W'(d_q[0]); mul_b = MB_W'(gv_q[0]); end
      M_RZ1:   begin mul_a = MA_W'(d_q[1]); mul_b = MB_W'(gv_q[1]); end
      M_RX0:   begin mul_a = MA_W'(d_q[0]); mul_b = MB_W'(gv_q[2]); end
      M_RX1:   begin mul_a = MA_W'(d_q[2]); mul_b = MB_W'(gv_q[1]); end
      M_RY0:   begin mul_a = MA_W'(d_q[1]); mul_b = MB_W'(gv_q[2]); end
      M_RY1:   begin mul_a = MA_W'(d_q[2]); mul_b = MB_W'(gv_q[0]); end
      M_BV0:   begin mul_a = inv_op; mul_b = MB_W'(gv_q[0]); end
      M_BA0:   begin mul_a = gain_op; mul_b = MB_W'(accw[0]); end
      M_BV1:   begin mul_a = inv_op; mul_b = MB_W'(gv_q[1]); end
      M_BA1:   begin mul_a = gain_op; mul_b = MB_W'(accw[1]); end
      M_BV2:   begin mul_a = inv_op; mul_b = MB_W'(gv_q[2]); end
      M_BA2:   begin mul_a = gain_op; mul_b = MB_W'(accw[2]); end
      default: ;
    endcase
  end

  assign sum_rnd22 = rnd_shr(64'(sum_q), 22);
  assign sum_rnd16 = rnd_shr(64'(sum_q), 16);

  // CORDIC load: pick the vector, then pre-rotate by a quarter turn when x is negative.
  assign gx     = CW'(gv_q[0]);
  assign gx_abs = gx[CW-1] ? -gx : gx;

  always_comb begin
    ld_x = '0;
    ld_y = '0;
    unique case (cmd_i.cord)
      C_LD_PITCH: begin ld_x = CW'(gv_q[2]); ld_y = CW'(gv_q[1]); end
      C_LD_KX:    begin ld_x = gx_abs; ld_y = '0; end
      C_LD_ROLL:  begin ld_x = r_q; ld_y = kx_q; end
      default:    ;
    endcase
    px   = ld_x;
    py   = ld_y;
    pang = '0;
    if (ld_x[CW-1]) begin
      if (!ld_y[CW-1]) begin
        px   = ld_y;
        py   = -ld_x;
        pang = ANG_HALF_PI;
      end else begin
        px   = -ld_y;
        py   = ld_x;
        pang = -ANG_HALF_PI;
      end
    end
  end

  assign xs      = cx_q >>> cmd_i.iter;
  assign ys      = cy_q >>> cmd_i.iter;
  assign tab     = AW'(signed'({1'b0, atan_q30(int'(cmd_i.iter))}));
  assign ang_fin = zero_q ? '0 : ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      update_gain_q <= 16'd131;
      init_gain_q   <= 16'd6554;
      gv_q[0]       <= '0;
      gv_q[1]       <= '0;
      gv_q[2]       <= GV_W'(64'sd1 <<< GV_FRAC);
      yaw_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_UPDATE_GAIN: update_gain_q <= cfg_data_i;
          CFG_INIT_GAIN:   init_gain_q   <= cfg_data_i;
          default:         ;
        endcase
      end
      if (cmd_i.load && cmd_bit_i) begin
        yaw_q <= '0;
      end
      if (cmd_i.acc == A_D2) begin
        yaw_q <= sat_yaw(64'(yaw_q) - rnd_shr(64'(prod_q), 13));
      end
      unique case (cmd_i.wr)
        W_COMMIT: begin
          gv_q[0] <= nv_q[0];
          gv_q[1] <= nv_q[1];
          gv_q[2] <= nv_q[2];
        end
        W_B0:    gv_q[0] <= sat_gv(sum_rnd16);
        W_B1:    gv_q[1] <= sat_gv(sum_rnd16);
        W_B2:    gv_q[2] <= sat_gv(sum_rnd16);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      init_q     <= cmd_bit_i;
      accel_q[0] <= accel_x_i;
      accel_q[1] <= accel_y_i;
      accel_q[2] <= accel_z_i;
      rate_q[0]  <= gyro_roll_rate_i;
      rate_q[1]  <= gyro_pitch_rate_i;
      rate_q[2]  <= gyro_yaw_rate_i;
      dt_q       <= dt_i;
    end

    prod_q <= P_W'(mul_a) * P_W'(mul_b);

    unique case (cmd_i.acc)
      A_D0:    d_q[0] <= D_W'(rnd_shr(64'(prod_q), 7));
      A_D1:    d_q[1] <= D_W'(rnd_shr(64'(prod_q), 7));
      A_D2:    d_q[2] <= D_W'(rnd_shr(64'(prod_q), 7));
      A_LOAD:  sum_q <= SUM_W'(prod_q);
      A_ADD:   sum_q <= sum_q + SUM_W'(prod_q);
      A_SUB:   sum_q <= sum_q - SUM_W'(prod_q);
      default: ;
    endcase

    unique case (cmd_i.wr)
      W_Z:     nv_q[2] <= sat_gv(64'(gv_q[2]) - sum_rnd22);
      W_X:     nv_q[0] <= sat_gv(64'(gv_q[0]) + sum_rnd22);
      W_Y:     nv_q[1] <= sat_gv(64'(gv_q[1]) + sum_rnd22);
      default: ;
    endcase

    unique case (cmd_i.cord) inside
      C_LD_PITCH, C_LD_KX, C_LD_ROLL: begin
        cx_q   <= px;
        cy_q   <= py;
        ang_q  <= pang;
        zero_q <= (ld_x == '0) && (ld_y == '0);
      end
      C_ITER: begin
        if (!cy_q[CW-1]) begin
          cx_q  <= cx_q + ys;
          cy_q  <= cy_q - xs;
          ang_q <= ang_q + tab;
        end else begin
          cx_q  <= cx_q - ys;
          cy_q  <= cy_q + xs;
          ang_q <= ang_q - tab;
        end
      end
      default: ;
    endcase

    unique case (cmd_i.done)
      N_PITCH: begin
        pitch_q <= 16'(rnd_shr(64'(ang_fin), 18));
        r_q     <= cx_q;
      end
      N_KX:    kx_q <= gx[CW-1] ? -cx_q : cx_q;
      default: ;
    endcase

    if (cmd_i.out_load) begin
      roll_out_q  <= 16'(rnd_shr(64'(ang_fin), 18));
      pitch_out_q <= pitch_q;
      yaw_out_q   <= yaw_q;
    end
  end

  assign roll_angle_o  = roll_out_q;
  assign pitch_angle_o = pitch_out_q;
  assign yaw_angle_o   = yaw_out_q;

endmodule

// ===== hdl/gravity_vector_attitude_estimator_unit.sv =====
// Top level of the gravity-vector attitude estimator.
//
// Input channel (in_valid_i / in_ready_o) takes one IMU sample per transfer:
// cmd_i = 0 rotates the stored gravity vector by the gyro deltas and blends
// it toward the accelerometer with update_gain; cmd_i = 1 blends with
// init_gain and clears the yaw integral. Output channel (out_valid_o /
// out_ready_i) returns roll, pitch and yaw for every sample.
// Configuration channel (cfg_valid_i / cfg_ready_o) writes update_gain at
// index 0 and init_gain at index 1; it is always ready, write it while idle.
//
// One sample is in work at a time; the next is taken once the result of the
// last has been loaded into the output register. The work per sample is set by
// the shared multiplier sequence (rotation and blend) and the one-iteration-per-
// cycle CORDIC, which runs three passes of 16 iterations.
// Reset restores the gravity vector to (0, 0, 1 g), clears yaw and loads the
// default gains. While the receiver stalls, the result is held and the next
// sample is still accepted; it waits in its final step until the output
// register is free.
module gravity_vector_attitude_estimator_unit import gvae_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] gyro_roll_rate_i,
  input  logic signed [15:0] gyro_pitch_rate_i,
  input  logic signed [15:0] gyro_yaw_rate_i,
  input  logic [19:0]        dt_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [15:0] pitch_angle_o,
  output logic signed [31:0] yaw_angle_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  gvae_cmd_t  cmd;
  gvae_stat_t stat;

  assign cfg_ready_o = 1'b1;

  gvae_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  gvae_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cmd_bit_i         (cmd_i),
    .accel_x_i         (accel_x_i),
    .accel_y_i         (accel_y_i),
    .accel_z_i         (accel_z_i),
    .gyro_roll_rate_i  (gyro_roll_rate_i),
    .gyro_pitch_rate_i (gyro_pitch_rate_i),
    .gyro_yaw_rate_i   (gyro_yaw_rate_i),
    .dt_i              (dt_i),
    .roll_angle_o      (roll_angle_o),
    .pitch_angle_o     (pitch_angle_o),
    .yaw_angle_o       (yaw_angle_o)
  );

endmodule

// ===== hdl/gvae_checker.sv =====
// Port-level checks of the estimator, bound to the top level.
module gvae_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] roll_angle_o,
  input logic signed [15:0] pitch_angle_o,
  input logic signed [31:0] yaw_angle_o,
  input logic               cfg_ready_o
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(roll_angle_o)
      && $stable(pitch_angle_o) && $stable(yaw_angle_o))
    else $error("stalled result changed");

  // One sample at a time: busy right after a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

  // No result appears in the cycle right after an input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result too early");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config port not ready");

endmodule

bind gravity_vector_attitude_estimator_unit gvae_checker u_gvae_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .roll_angle_o  (roll_angle_o),
  .pitch_angle_o (pitch_angle_o),
  .yaw_angle_o   (yaw_angle_o),
  .cfg_ready_o   (cfg_ready_o)
);

// ===== dv/gravity_vector_attitude_estimator_unit_test.sv =====
// Self-checking testbench for the gravity-vector attitude estimator top level.
`timescale 1ns / 100ps

module gravity_vector_attitude_estimator_unit_test;
  import gvae_pkg::*;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_INIT   = 1'b1;
  localparam logic REG_UPDATE_GAIN = 1'b0;
  localparam logic REG_INIT_GAIN   = 1'b1;
  localparam int   DRAIN_CYCLES    = 100;
  localparam longint HALF_PI_Q30   = 64'sd1686629713;
  localparam longint ARCTAN_Q30 [TAB_LEN] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127};

  typedef longint vec3_t [3];
  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [31:0] yaw;
  } attitude_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               cmd_i = CMD_UPDATE;
  logic signed [15:0] accel_x_i = '0;
  logic signed [15:0] accel_y_i = '0;
  logic signed [15:0] accel_z_i = '0;
  logic signed [15:0] gyro_roll_rate_i = '0;
  logic signed [15:0] gyro_pitch_rate_i = '0;
  logic signed [15:0] gyro_yaw_rate_i = '0;
  logic [19:0]        dt_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] roll_angle_o;
  logic signed [15:0] pitch_angle_o;
  logic signed [31:0] yaw_angle_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i = REG_UPDATE_GAIN;
  logic [15:0]        cfg_data_i = '0;

  // Predictor state
  vec3_t       gravity_est;
  longint      yaw_sum;
  logic [15:0] update_gain_q;
  logic [15:0] init_gain_q;

  attitude_t expected_attitude[$];
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        error_count = 0;
  int        samples_sent = 0;
  int        attitudes_checked = 0;
  int        init_samples = 0;
  int        gain_writes = 0;

  gravity_vector_attitude_estimator_unit dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #(50_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic longint round_shift(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Vectoring CORDIC: angle of (x, y) in Q.30, gain-scaled magnitude in mag.
  function automatic longint cordic_atan2(longint xi, longint yi, output longint mag);
    longint x, y, ang, t, xs, ys;
    x = xi;
    y = yi;
    ang = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; ang = HALF_PI_Q30;
      end else begin
        x = -y; y = t; ang = -HALF_PI_Q30;
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < TAB_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; ang += ARCTAN_Q30[i];
      end else begin
        x -= ys; y += xs; ang -= ARCTAN_Q30[i];
      end
    end
    mag = x;
    return ang;
  endfunction

  function automatic void blend_toward(vec3_t acc, logic [15:0] g);
    longint s;
    for (int i = 0; i < 3; i++) begin
      s = gravity_est[i] * (65536 - longint'(g)) + acc[i] * longint'(g);
      gravity_est[i] = clamp_to(round_shift(s, 16), GV_MIN, GV_MAX);
    end
  endfunction

  function automatic attitude_t predict_attitude(logic c, logic signed [15:0] ax,
      logic signed [15:0] ay, logic signed [15:0] az, logic signed [15:0] gr,
      logic signed [15:0] gp, logic signed [15:0] gy, logic [19:0] dt);
    vec3_t acc, d;
    longint rate [3];
    longint x, y, z, r, kx, gx, pitch, roll, mag, dtl;
    attitude_t res;
    dtl = longint'(dt);
    acc[0] = longint'(ax) * (64'sd1 <<< ACC_SHIFT);
    acc[1] = longint'(ay) * (64'sd1 <<< ACC_SHIFT);
    acc[2] = longint'(az) * (64'sd1 <<< ACC_SHIFT);
    rate[0] = longint'(gr);
    rate[1] = longint'(gp);
    rate[2] = longint'(gy);
    if (c == CMD_INIT) begin
      blend_toward(acc, init_gain_q);
      yaw_sum = 0;
    end else begin
      for (int i = 0; i < 3; i++) d[i] = round_shift(rate[i] * dtl, 7);
      x = gravity_est[0];
      y = gravity_est[1];
      z = gravity_est[2];
      gravity_est[2] = clamp_to(z - round_shift(d[0] * x + d[1] * y, 22), GV_MIN, GV_MAX);
      gravity_est[0] = clamp_to(x + round_shift(d[0] * z - d[2] * y, 22), GV_MIN, GV_MAX);
      gravity_est[1] = clamp_to(y + round_shift(d[1] * z + d[2] * x, 22), GV_MIN, GV_MAX);
      blend_toward(acc, update_gain_q);
      yaw_sum = clamp_to(yaw_sum - round_shift(rate[2] * dtl, 13), YAW_MIN, YAW_MAX);
    end
    pitch = cordic_atan2(gravity_est[2], gravity_est[1], r);
    gx = gravity_est[0];
    void'(cordic_atan2((gx < 0) ? -gx : gx, 0, kx));
    if (gx < 0) kx = -kx;
    roll = cordic_atan2(r, kx, mag);
    res.roll  = 16'(round_shift(roll, 18));
    res.pitch = 16'(round_shift(pitch, 18));
    res.yaw   = 32'(yaw_sum);
    return res;
  endfunction

  // Check every result transfer and drive receiver stalls.
  always @(posedge clk_i) begin
    attitude_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_attitude.size() == 0) begin
        $error("unexpected result: roll %0d pitch %0d yaw %0d",
               roll_angle_o, pitch_angle_o, yaw_angle_o);
        error_count++;
      end else begin
        e = expected_attitude.pop_front();
        attitudes_checked++;
        if (roll_angle_o !== e.roll) begin
          $error("roll_angle: expected %0d, got %0d", e.roll, roll_angle_o);
          error_count++;
        end
        if (pitch_angle_o !== e.pitch) begin
          $error("pitch_angle: expected %0d, got %0d", e.pitch, pitch_angle_o);
          error_count++;
        end
        if (yaw_angle_o !== e.yaw) begin
          $error("yaw_angle: expected %0d, got %0d", e.yaw, yaw_angle_o);
          error_count++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_sample(logic c, logic signed [15:0] ax, logic signed [15:0] ay,
      logic signed [15:0] az, logic signed [15:0] gr, logic signed [15:0] gp,
      logic signed [15:0] gy, logic [19:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    cmd_i             <= c;
    accel_x_i         <= ax;
    accel_y_i         <= ay;
    accel_z_i         <= az;
    gyro_roll_rate_i  <= gr;
    gyro_pitch_rate_i <= gp;
    gyro_yaw_rate_i   <= gy;
    dt_i              <= dt;
    do @(posedge clk_i); while (!in_ready_o);
    expected_attitude.push_back(predict_attitude(c, ax, ay, az, gr, gp, gy, dt));
    samples_sent++;
    if (c == CMD_INIT) init_samples++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_attitude.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Only call while the block is idle.
  task automatic write_gain(logic idx, logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_UPDATE_GAIN) update_gain_q = value;
    else init_gain_q = value;
    gain_writes++;
  endtask

  task automatic test_field_extremes();
    send_sample(CMD_UPDATE, 16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'sd0, 20'd0);
    send_sample(CMD_UPDATE, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                16'sh7fff, 16'sh7fff, 16'sh7fff, 20'hfffff);
    send_sample(CMD_UPDATE, -16'sh8000, -16'sh8000, -16'sh8000,
                -16'sh8000, -16'sh8000, -16'sh8000, 20'hfffff);
    send_sample(CMD_UPDATE, 16'sh7fff, -16'sh8000, 16'sh7fff,
                -16'sh8000, 16'sh7fff, -16'sh8000, 20'h80000);
    // Drive yaw into positive saturation, then back it off.
    repeat (520) send_sample(CMD_UPDATE, 16'sd0, 16'sd0, 16'sd4096,
                             16'sd0, 16'sd0, -16'sh8000, 20'hfffff);
    repeat (5) send_sample(CMD_UPDATE, 16'sd0, 16'sd0, 16'sd4096,
                           16'sd0, 16'sd0, 16'sh7fff, 20'hfffff);
  endtask

  task automatic test_init_quadrants();
    // Init clears yaw and ignores gyro and dt; walk pitch through every quadrant.
    send_sample(CMD_INIT, 16'sd0, 16'sd4096, -16'sd4096, 16'sh7fff, 16'sh7fff,
                16'sh7fff, 20'hfffff);
    send_sample(CMD_INIT, 16'sd4096, -16'sd4096, -16'sd4096, 16'sd0, 16'sd0, 16'sd0, 20'd0);
    send_sample(CMD_INIT, -16'sd4096, -16'sd4096, 16'sd4096, 16'sd0, 16'sd0, 16'sd0, 20'd0);
    send_sample(CMD_INIT, 16'sd0, 16'sd0, -16'sh8000, 16'sd0, 16'sd0, 16'sd0, 20'd0);
  endtask

  task automatic test_gain_extremes();
    wait_idle();
    write_gain(REG_INIT_GAIN, 16'hffff);
    write_gain(REG_UPDATE_GAIN, 16'h0000);
    // Zero accel at full init weight collapses the vector to zero.
    repeat (3) send_sample(CMD_INIT, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'd0);
    // Zero update weight keeps the vector; zero vector stays zero.
    send_sample(CMD_UPDATE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sd100, 16'sd100,
                16'sd100, 20'd1000);
    send_sample(CMD_INIT, -16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'd0);
    send_sample(CMD_UPDATE, 16'sd0, 16'sd0, 16'sd0, 16'sd512, -16'sd512, 16'sd0, 20'd2000);
    wait_idle();
    write_gain(REG_UPDATE_GAIN, 16'hffff);
    write_gain(REG_INIT_GAIN, 16'h0000);
    send_sample(CMD_INIT, 16'sd4096, 16'sd4096, 16'sd4096, 16'sd0, 16'sd0, 16'sd0, 20'd0);
    send_sample(CMD_UPDATE, 16'sd0, -16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'd0);
  endtask

  task automatic test_random_motion(int count);
    logic               c;
    logic signed [15:0] a [3];
    logic signed [15:0] w [3];
    logic [19:0]        dt;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) < 7) begin
        // Plausible motion: accel within 1 g per axis, modest rates, short steps.
        c = ($urandom_range(19) == 0) ? CMD_INIT : CMD_UPDATE;
        for (int k = 0; k < 3; k++) begin
          a[k] = 16'($signed($urandom_range(8192)) - 4096);
          w[k] = 16'($signed($urandom_range(2048)) - 1024);
        end
        dt = 20'($urandom_range(4000));
      end else begin
        c = 1'($urandom);
        for (int k = 0; k < 3; k++) begin
          a[k] = 16'($urandom);
          w[k] = 16'($urandom);
        end
        dt = 20'($urandom);
      end
      send_sample(c, a[0], a[1], a[2], w[0], w[1], w[2], dt);
    end
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 3; p++) begin
      wait_idle();
      send_idle_pct = (p == 0) ? 33 : ((p == 1) ? 79 : 0);
      recv_idle_pct = (p == 0) ? 79 : ((p == 1) ? 33 : 0);
      write_gain(REG_UPDATE_GAIN, (p == 0) ? 16'd131 : 16'($urandom_range(8000)));
      write_gain(REG_INIT_GAIN, (p == 2) ? 16'hffff : 16'($urandom));
      test_random_motion(460);
    end
  endtask

  initial begin
    gravity_est[0] = 0;
    gravity_est[1] = 0;
    gravity_est[2] = 64'sd1 <<< GV_FRAC;
    yaw_sum = 0;
    update_gain_q = 16'd131;
    init_gain_q = 16'd6554;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_init_quadrants();
    test_gain_extremes();
    test_random_phases();
    wait_idle();
    $display("Sent %0d samples (%0d init), checked %0d attitudes, %0d gain writes.",
             samples_sent, init_samples, attitudes_checked, gain_writes);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
